// File: rtl/odq_pkg.sv
// ----------------------------------------------------------------------------
// odq_pkg: shared types and constants of the ordered-dither palette quantizer
// Item record carried along the cell chain, palette geometry, CSR codes.
// ----------------------------------------------------------------------------
package odq_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int FIRST_ENTRY   = 4;
   localparam int CELL_COUNT    = PALETTE_DEPTH - FIRST_ENTRY;
   localparam int INDEX_WIDTH   = 8;
   localparam int COLOR_WIDTH   = 8;
   localparam int COUNT_WIDTH   = 9;
   localparam int SUM_WIDTH     = 10;   // signed, covers -15..270
   localparam int SQ_WIDTH      = 17;   // one squared channel difference
   localparam int DIST_WIDTH    = 18;   // sum of three squares

   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 9'd5;

   // CSR register index (byte address / 4)
   localparam logic REG_PALETTE_COUNT = 1'b0;

   // tuser codes of the request channel
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   typedef logic signed [SUM_WIDTH-1:0] odq_sum_type;

   typedef struct packed {
      logic                    valid;
      logic                    pixel;        // 1: pixel, 0: palette write
      logic                    opaque;
      logic [INDEX_WIDTH-1:0]  entry_index;
      odq_sum_type             red;
      odq_sum_type             green;
      odq_sum_type             blue;
      logic [INDEX_WIDTH-1:0]  best_index;
      logic [DIST_WIDTH-1:0]   best_dist;
   } odq_item_type;

endpackage

// File: rtl/ordered_dither_palette_quantizer.sv
// ----------------------------------------------------------------------------
// ordered_dither_palette_quantizer: 16x16 Bayer dither + nearest palette index
// Path from a request transfer to its response: 1 front stage,
//   2 stages in each of 252 palette cells, 1 output register.
// Throughput: one item per cycle; the whole chain stalls while a response waits.
// Reset clears all item valid flags and sets palette_count to 5; palette
//   entries keep no reset value and hold garbage until written.
// ----------------------------------------------------------------------------
module ordered_dither_palette_quantizer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // entry_index[7:0], red[15:8], green[23:16],
                                   // blue[31:24], alpha[39:32], column[46:40],
                                   // row[53:47], zero pad[55:54]
   input  logic        req_tuser,  // mode: 0 palette write, 1 pixel
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // colour_index[7:0]
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import odq_pkg::*;

   logic                    advance;
   logic [COUNT_WIDTH-1:0]  palette_count_ff;
   logic                    csr_write;
   odq_item_type            chain [0:CELL_COUNT];
   odq_item_type            last_item;
   logic                    rsp_valid_ff;
   logic [INDEX_WIDTH-1:0]  rsp_index_ff;

   // The chain moves as one: advance whenever the output register is free
   // or its transfer completes this cycle.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // ---------------------------------------------------------------- CSR ---
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_count_ff <= COUNT_RESET;
      end else if (csr_write && (csr_paddr[2] == REG_PALETTE_COUNT)) begin
         palette_count_ff <= csr_pwdata[COUNT_WIDTH-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_PALETTE_COUNT) begin
         csr_prdata = {{(32-COUNT_WIDTH){1'b0}}, palette_count_ff};
      end
   end

   // ------------------------------------------------------ front stage ---
   // Dither level, opacity and color offset; palette writes pass untouched.
   odq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (req_tvalid),
      .in_mode        (req_tuser),
      .in_entry_index (req_tdata[7:0]),
      .in_red         (req_tdata[15:8]),
      .in_green       (req_tdata[23:16]),
      .in_blue        (req_tdata[31:24]),
      .in_alpha       (req_tdata[39:32]),
      .in_column      (req_tdata[46:40]),
      .in_row         (req_tdata[53:47]),
      .item_out       (chain[0])
   );

   // ------------------------------------------------------- cell chain ---
   // One cell per searchable entry (4..255). Writes and pixels travel the
   // same chain in order, so every cell sees them in transfer order.
   // Writes to entries below four are never read and drop off the end.
   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      odq_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .cell_idx      (INDEX_WIDTH'(FIRST_ENTRY + i)),
         .palette_count (palette_count_ff),
         .item_in       (chain[i]),
         .item_out      (chain[i+1])
      );
   end

   assign last_item = chain[CELL_COUNT];

   // ---------------------------------------------------- output register ---
   // Pixels give one response; transparent pixels report index zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last_item.valid && last_item.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_index_ff <= last_item.opaque ? last_item.best_index : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_index_ff;

endmodule

// File: rtl/odq_front.sv
// ----------------------------------------------------------------------------
// odq_front: dither front stage
// Looks up the Bayer level, decides opacity, applies the color offset.
// ----------------------------------------------------------------------------
module odq_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic                 in_mode,
   input  logic [7:0]           in_entry_index,
   input  logic [7:0]           in_red,
   input  logic [7:0]           in_green,
   input  logic [7:0]           in_blue,
   input  logic [7:0]           in_alpha,
   input  logic [6:0]           in_column,
   input  logic [6:0]           in_row,
   output odq_pkg::odq_item_type item_out
);
   import odq_pkg::*;

   logic [3:0]         x_pos;
   logic [3:0]         y_pos;
   logic [3:0]         xy_pos;
   logic [7:0]         level;
   logic [16:0]        opacity_sum;
   logic               opaque;
   logic signed [9:0]  level_centered;
   logic signed [17:0] offset_scaled;
   logic signed [17:0] offset_rounded;
   logic signed [4:0]  offset;
   odq_item_type       item_ff;
   odq_item_type       item_in;

   assign x_pos  = in_column[3:0];
   assign y_pos  = in_row[3:0];
   assign xy_pos = x_pos ^ y_pos;

   // interleave: lowest coordinate bit lands in the top level bits
   assign level = {xy_pos[0], y_pos[0], xy_pos[1], y_pos[1],
                   xy_pos[2], y_pos[2], xy_pos[3], y_pos[3]};

   assign opacity_sum = {1'b0, in_alpha, 8'd0} + {1'b0, level, 8'd0} - {9'd0, level};
   assign opaque      = (in_alpha != 8'd0) && (opacity_sum >= 17'd65280);

   // offset = 255*(k-128)/2048, truncated toward zero
   assign level_centered = $signed({2'b00, level}) - 10'sd128;
   assign offset_scaled  = (18'(level_centered) <<< 8) - 18'(level_centered);
   assign offset_rounded = offset_scaled[17] ? offset_scaled + 18'sd2047 : offset_scaled;
   assign offset         = 5'(offset_rounded >>> 11);

   always_comb begin
      item_in             = '0;
      item_in.valid       = in_valid;
      item_in.pixel       = (in_mode == MODE_PIXEL);
      item_in.opaque      = opaque;
      item_in.entry_index = in_entry_index;
      if (in_mode == MODE_PIXEL) begin
         item_in.red   = $signed({2'b00, in_red})   + SUM_WIDTH'(offset);
         item_in.green = $signed({2'b00, in_green}) + SUM_WIDTH'(offset);
         item_in.blue  = $signed({2'b00, in_blue})  + SUM_WIDTH'(offset);
      end else begin
         item_in.red   = $signed({2'b00, in_red});
         item_in.green = $signed({2'b00, in_green});
         item_in.blue  = $signed({2'b00, in_blue});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         item_ff <= item_in;
      end
   end

   assign item_out = item_ff;

endmodule

// File: rtl/odq_cell.sv
// ----------------------------------------------------------------------------
// odq_cell: one palette cell of the search chain
// Holds one palette entry; stage A takes writes and forms the distance,
// stage B keeps the running best.
// ----------------------------------------------------------------------------
module odq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [7:0]             cell_idx,
   input  logic [8:0]             palette_count,
   input  odq_pkg::odq_item_type  item_in,
   output odq_pkg::odq_item_type  item_out
);
   import odq_pkg::*;

   logic [3*COLOR_WIDTH-1:0]  entry_ff;
   odq_sum_type               diff_r;
   odq_sum_type               diff_g;
   odq_sum_type               diff_b;
   logic [SQ_WIDTH-1:0]       sq_r;
   logic [SQ_WIDTH-1:0]       sq_g;
   logic [SQ_WIDTH-1:0]       sq_b;
   logic [DIST_WIDTH-1:0]     dist_in;
   logic [DIST_WIDTH-1:0]     dist_ff;
   odq_item_type              a_ff;
   odq_item_type              b_ff;
   odq_item_type              b_in;
   logic                      first;
   logic                      active;
   logic                      take;

   assign diff_r = $signed({2'b00, entry_ff[23:16]}) - item_in.red;
   assign diff_g = $signed({2'b00, entry_ff[15:8]})  - item_in.green;
   assign diff_b = $signed({2'b00, entry_ff[7:0]})   - item_in.blue;
   assign sq_r   = SQ_WIDTH'(diff_r) * SQ_WIDTH'(diff_r);
   assign sq_g   = SQ_WIDTH'(diff_g) * SQ_WIDTH'(diff_g);
   assign sq_b   = SQ_WIDTH'(diff_b) * SQ_WIDTH'(diff_b);
   assign dist_in = DIST_WIDTH'(sq_r) + DIST_WIDTH'(sq_g) + DIST_WIDTH'(sq_b);

   // stage A: capture a write addressed here, register the distance
   always_ff @(posedge clock) begin
      if (advance && item_in.valid && !item_in.pixel && (item_in.entry_index == cell_idx)) begin
         entry_ff <= {item_in.red[7:0], item_in.green[7:0], item_in.blue[7:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
      end else if (advance) begin
         a_ff <= item_in;
      end
   end

   // stage B: the first searched entry always seeds the best, strict less wins
   assign first  = (cell_idx == 8'(FIRST_ENTRY));
   assign active = ({1'b0, cell_idx} < palette_count);
   assign take   = a_ff.valid && a_ff.pixel && (first || (active && (dist_ff < a_ff.best_dist)));

   always_comb begin
      b_in = a_ff;
      if (take) begin
         b_in.best_index = cell_idx;
         b_in.best_dist  = dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else if (advance) begin
         b_ff <= b_in;
      end
   end

   assign item_out = b_ff;

endmodule
